>>> src/impulse_switching_median_3x3_core_assert.svh
// Assertion macros for the switching median filter RTL.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef IMPULSE_SWITCHING_MEDIAN_3X3_CORE_ASSERT_SVH
`define IMPULSE_SWITCHING_MEDIAN_3X3_CORE_ASSERT_SVH

// same-cycle implication
`define ISFM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ISFM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/isfm_pkg.sv
// Shared types, codes and compare helpers for the switching median filter.
// No dependencies.
`default_nettype none

package isfm_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL = 2'd3;

	localparam logic [10:0] FRAME_WIDTH_RST = 11'd640;
	localparam logic [10:0] FRAME_HEIGHT_RST = 11'd480;
	localparam logic [7:0] LOW_LEVEL_RST = 8'd0;
	localparam logic [7:0] HIGH_LEVEL_RST = 8'd255;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef logic [7:0] pix_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	typedef struct packed {
		pix_t lo;
		pix_t md;
		pix_t hi;
	} triple_t;

	typedef struct packed {
		col_t c0;
		col_t c1;
		col_t c2;
		logic do_main;
		logic do_edge;
		logic is_last;
	} job_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		return min2(min2(a, b), c);
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		return max2(max2(a, b), c);
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	function automatic triple_t sort3(input col_t c);
		triple_t t;
		t.lo = min3(c.top, c.mid, c.bot);
		t.md = med3(c.top, c.mid, c.bot);
		t.hi = max3(c.top, c.mid, c.bot);
		return t;
	endfunction

endpackage

`default_nettype wire

>>> src/isfm_front.sv
// Front end: accepts pixel and drain words, keeps the row/column counters,
// two ping-pong line buffers and the 3x3 window, and pushes filter jobs.
// Depends on isfm_pkg.
`default_nettype none

module isfm_front #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         opcode,
	input  wire isfm_pkg::pix_t               pixel,
	input  wire logic [10:0]                  frame_width,
	input  wire logic [10:0]                  frame_height,
	input  wire logic [isfm_pkg::QCNT_W-1:0]  q_level,
	output logic                              push,
	output isfm_pkg::job_t                    job
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int WXW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
	localparam int HXW = ($clog2(MAX_HEIGHT + 1) > 11) ? $clog2(MAX_HEIGHT + 1) : 11;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          sel_q;

	logic [WXW-1:0] width_x;
	logic [HXW-1:0] height_x;
	logic [CW-1:0]  last_col;
	logic [RW-1:0]  h_eff;
	logic           row_end;
	logic           draining;
	logic           is_drain;
	logic           acc;
	logic           acc_ok;

	isfm_pkg::pix_t mem0 [MAX_WIDTH];
	isfm_pkg::pix_t mem1 [MAX_WIDTH];
	isfm_pkg::pix_t rd0_s1;
	isfm_pkg::pix_t rd1_s1;

	logic           v_s1;
	logic           col0_s1;
	logic           row_end_s1;
	logic           last_s1;
	logic           dup_top_s1;
	logic           drain_s1;
	logic           sel_s1;
	isfm_pkg::pix_t pix_s1;

	isfm_pkg::col_t w0_q;
	isfm_pkg::col_t w1_q;
	isfm_pkg::col_t w2_q;
	isfm_pkg::col_t ncol;
	isfm_pkg::col_t nw0;
	isfm_pkg::col_t nw1;
	isfm_pkg::col_t nw2;
	isfm_pkg::pix_t upper;
	isfm_pkg::pix_t lower;
	logic [isfm_pkg::QCNT_W:0] room_need;

	assign width_x = WXW'(frame_width);
	assign height_x = HXW'(frame_height);

	always_comb begin
		if (frame_width == 11'd0) begin
			last_col = '0;
		end else if (width_x > WXW'(MAX_WIDTH)) begin
			last_col = CW'(MAX_WIDTH - 1);
		end else begin
			last_col = CW'(width_x - WXW'(1));
		end
		if (frame_height == 11'd0) begin
			h_eff = RW'(1);
		end else if (height_x > HXW'(MAX_HEIGHT)) begin
			h_eff = RW'(MAX_HEIGHT);
		end else begin
			h_eff = RW'(height_x);
		end
	end

	assign row_end = col_q >= last_col;
	assign draining = row_q >= h_eff;
	assign is_drain = opcode == isfm_pkg::OP_DRAIN;

	assign room_need = {1'b0, q_level} + (isfm_pkg::QCNT_W + 1)'(v_s1);
	assign in_stall = room_need >= (isfm_pkg::QCNT_W + 1)'(isfm_pkg::QDEPTH);
	assign acc = in_valid && !in_stall;
	assign acc_ok = acc && (is_drain == draining);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sel_q <= 1'b0;
		end else if (acc_ok) begin
			if (row_end) begin
				col_q <= '0;
				if (draining) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + RW'(1);
					sel_q <= !sel_q;
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// lower row lives in mem[sel], upper row in mem[!sel]; new pixels overwrite the upper row
	always_ff @(posedge clk) begin
		if (acc_ok && !is_drain && sel_q) begin
			mem0[col_q] <= pixel;
		end
		rd0_s1 <= mem0[col_q];
	end

	always_ff @(posedge clk) begin
		if (acc_ok && !is_drain && !sel_q) begin
			mem1[col_q] <= pixel;
		end
		rd1_s1 <= mem1[col_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc_ok && (row_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		col0_s1 <= col_q == '0;
		row_end_s1 <= row_end;
		last_s1 <= draining && row_end;
		dup_top_s1 <= (row_q == RW'(1)) || (draining && (h_eff == RW'(1)));
		drain_s1 <= is_drain;
		sel_s1 <= sel_q;
		pix_s1 <= pixel;
	end

	assign upper = sel_s1 ? rd0_s1 : rd1_s1;
	assign lower = sel_s1 ? rd1_s1 : rd0_s1;

	always_comb begin
		ncol.top = dup_top_s1 ? lower : upper;
		ncol.mid = lower;
		ncol.bot = drain_s1 ? lower : pix_s1;
		if (col0_s1) begin
			nw0 = ncol;
			nw1 = ncol;
			nw2 = ncol;
		end else begin
			nw0 = w1_q;
			nw1 = w2_q;
			nw2 = ncol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0;
			w1_q <= '0;
			w2_q <= '0;
		end else if (v_s1) begin
			w0_q <= nw0;
			w1_q <= nw1;
			w2_q <= nw2;
		end
	end

	assign push = v_s1 && (!col0_s1 || row_end_s1);
	assign job.c0 = nw0;
	assign job.c1 = nw1;
	assign job.c2 = nw2;
	assign job.do_main = !col0_s1;
	assign job.do_edge = row_end_s1;
	assign job.is_last = last_s1;

endmodule

`default_nettype wire

>>> src/isfm_queue.sv
// Job queue between front and back end: a small register FIFO with a level count.
// Depends on isfm_pkg and the assertion macro header.
`default_nettype none

`include "impulse_switching_median_3x3_core_assert.svh"

module isfm_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire isfm_pkg::job_t               push_job,
	input  wire logic                         pop,
	output isfm_pkg::job_t                    head,
	output logic                              not_empty,
	output logic [isfm_pkg::QCNT_W-1:0]       level
);

	isfm_pkg::job_t                  slot_q [isfm_pkg::QDEPTH];
	logic [isfm_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [isfm_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [isfm_pkg::QCNT_W-1:0]     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + isfm_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + isfm_pkg::QPTR_W'(1);
			end
			count_q <= count_q + isfm_pkg::QCNT_W'(push) - isfm_pkg::QCNT_W'(pop);
		end
	end

	assign head = slot_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign level = count_q;

	`ISFM_ASSERT_NOW(a_no_overflow, push, count_q != isfm_pkg::QCNT_W'(isfm_pkg::QDEPTH), "job queue overflow")
	`ISFM_ASSERT_NOW(a_no_underflow, pop, count_q != '0, "job queue underflow")
	`ISFM_ASSERT_NOW(a_empty_ptrs, count_q == '0, wr_ptr_q == rd_ptr_q, "empty queue with unequal pointers")
	`ISFM_ASSERT_NEXT(a_level_track, 1'b1, count_q == $past(count_q) + isfm_pkg::QCNT_W'($past(push)) - isfm_pkg::QCNT_W'($past(pop)), "queue level mismatch")

endmodule

`default_nettype wire

>>> src/isfm_back.sv
// Back end: expands jobs into one or two windows, runs the 3x3 median network
// in three stages and holds the output word. Depends on isfm_pkg.
`default_nettype none

module isfm_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire isfm_pkg::job_t head,
	input  wire logic           not_empty,
	output logic                pop,
	input  wire isfm_pkg::pix_t low_level,
	input  wire isfm_pkg::pix_t high_level,
	output logic                out_valid,
	input  wire logic           out_stall,
	output isfm_pkg::pix_t      value,
	output logic                replaced,
	output logic                last
);

	logic                phase_q;
	logic                en;
	logic                issue;
	logic                sel_edge;
	isfm_pkg::col_t      ca;
	isfm_pkg::col_t      cb;

	logic                v_s1;
	isfm_pkg::triple_t   ta_s1;
	isfm_pkg::triple_t   tb_s1;
	isfm_pkg::triple_t   tc_s1;
	isfm_pkg::pix_t      centre_s1;
	logic                last_s1;

	logic                v_s2;
	isfm_pkg::pix_t      lo_s2;
	isfm_pkg::pix_t      md_s2;
	isfm_pkg::pix_t      hi_s2;
	isfm_pkg::pix_t      gmin_s2;
	isfm_pkg::pix_t      gmax_s2;
	isfm_pkg::pix_t      centre_s2;
	logic                last_s2;

	logic                out_valid_q;
	isfm_pkg::pix_t      value_q;
	logic                replaced_q;
	logic                last_q;
	logic                hit;

	assign en = !(out_valid_q && out_stall);
	assign issue = en && not_empty;
	assign sel_edge = phase_q || !head.do_main;
	assign pop = issue && (sel_edge || !head.do_edge);

	assign ca = sel_edge ? head.c1 : head.c0;
	assign cb = sel_edge ? head.c2 : head.c1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (issue) begin
				phase_q <= !sel_edge && head.do_edge;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s1 <= isfm_pkg::sort3(ca);
			tb_s1 <= isfm_pkg::sort3(cb);
			tc_s1 <= isfm_pkg::sort3(head.c2);
			centre_s1 <= cb.mid;
			last_s1 <= sel_edge && head.is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2 <= isfm_pkg::max3(ta_s1.lo, tb_s1.lo, tc_s1.lo);
			md_s2 <= isfm_pkg::med3(ta_s1.md, tb_s1.md, tc_s1.md);
			hi_s2 <= isfm_pkg::min3(ta_s1.hi, tb_s1.hi, tc_s1.hi);
			gmin_s2 <= isfm_pkg::min3(ta_s1.lo, tb_s1.lo, tc_s1.lo);
			gmax_s2 <= isfm_pkg::max3(ta_s1.hi, tb_s1.hi, tc_s1.hi);
			centre_s2 <= centre_s1;
			last_s2 <= last_s1;
		end
	end

	assign hit = (gmin_s2 == low_level) || (gmax_s2 == high_level);

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= hit ? isfm_pkg::med3(lo_s2, md_s2, hi_s2) : centre_s2;
			replaced_q <= hit;
			last_q <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign replaced = replaced_q;
	assign last = last_q;

endmodule

`default_nettype wire

>>> src/impulse_switching_median_3x3_core.sv
// Top level of the 3x3 switching median filter: configuration registers,
// front end, job queue and back end. Depends on isfm_pkg and the isfm_* modules.
// Throughput: one input word per cycle while in_stall is low; a row-end word of a row
// wider than one pixel yields two results, balanced by the next row's first word, which
// yields none. A result is registered in front s1, a queue slot, back s1, s2 and output.
// Reset: counters, window, queue and pipeline valids clear; line buffers are not cleared.
`default_nettype none

module impulse_switching_median_3x3_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [isfm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [isfm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic [7:0]                        pixel,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [7:0]                             value,
	output logic                                   replaced,
	output logic                                   last
);

	logic [10:0]                    frame_width_q;
	logic [10:0]                    frame_height_q;
	isfm_pkg::pix_t                 low_level_q;
	isfm_pkg::pix_t                 high_level_q;

	logic                           push;
	isfm_pkg::job_t                 push_job;
	logic                           pop;
	isfm_pkg::job_t                 head;
	logic                           not_empty;
	logic [isfm_pkg::QCNT_W-1:0]    level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= isfm_pkg::FRAME_WIDTH_RST;
			frame_height_q <= isfm_pkg::FRAME_HEIGHT_RST;
			low_level_q <= isfm_pkg::LOW_LEVEL_RST;
			high_level_q <= isfm_pkg::HIGH_LEVEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				isfm_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				isfm_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
				isfm_pkg::REG_LOW_LEVEL: begin
					low_level_q <= cfg_data[7:0];
				end
				isfm_pkg::REG_HIGH_LEVEL: begin
					high_level_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	isfm_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.pixel       (pixel),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.q_level     (level),
		.push        (push),
		.job         (push_job)
	);

	isfm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.level    (level)
	);

	isfm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.low_level (low_level_q),
		.high_level(high_level_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.replaced  (replaced),
		.last      (last)
	);

endmodule

`default_nettype wire

>>> sim/isfm_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the 3x3 switching median filter: tracks register writes and
// accepted input words, predicts each filtered word and compares it in order.
// Depends on isfm_pkg for the register and opcode codes.
module isfm_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic                              cfg_ready,
	input  wire logic [isfm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [isfm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic                              opcode,
	input  wire logic [7:0]                        pixel,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic [7:0]                        value,
	input  wire logic                              replaced,
	input  wire logic                              last,
	output int                                     fail_count,
	output int                                     pending
);
	import isfm_pkg::*;

	localparam int LINE_MAX = 1024;

	typedef logic [8:0][7:0] win_t;

	typedef struct packed {
		pix_t value;
		logic replaced;
		logic last;
	} filt_word_t;

	logic [10:0] width_reg;
	logic [10:0] height_reg;
	pix_t        low_lvl;
	pix_t        high_lvl;
	pix_t        upper_line [LINE_MAX];
	pix_t        lower_line [LINE_MAX];
	win_t        win;
	logic [9:0]  col;
	logic [10:0] row;
	filt_word_t  filtered_q [$];
	filt_word_t  head;
	int          errs;
	int          i;

	function automatic int clamp_size(input logic [10:0] v, input int maxv);
		if (v == 11'd0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	function automatic filt_word_t switch_median(input win_t wv, input logic is_last);
		win_t       s;
		pix_t       t;
		int         k;
		int         j;
		logic       hit;
		filt_word_t r;
		s = wv;
		for (k = 1; k < 9; k++) begin
			t = s[k];
			j = k - 1;
			while (j >= 0 && s[j] > t) begin
				s[j + 1] = s[j];
				j--;
			end
			s[j + 1] = t;
		end
		hit = (s[0] == low_lvl) || (s[8] == high_lvl);
		r.value = hit ? s[4] : wv[4];
		r.replaced = hit;
		r.last = is_last;
		return r;
	endfunction

	task automatic filter_word(input logic op, input pix_t px);
		int   w;
		int   h;
		int   k;
		logic drain;
		logic draining;
		logic row_end;
		pix_t top;
		pix_t mid;
		pix_t bot;
		win_t rim;
		w = clamp_size(width_reg, LINE_MAX);
		h = clamp_size(height_reg, LINE_MAX);
		drain = (op == OP_DRAIN);
		draining = int'(row) >= h;
		row_end = int'(col) >= w - 1;
		if (drain != draining)
			return;
		top = upper_line[col];
		mid = lower_line[col];
		bot = drain ? mid : px;
		if (row == 11'd1 || (draining && h == 1))
			top = mid;
		if (!drain) begin
			upper_line[col] = mid;
			lower_line[col] = px;
		end
		if (row != 11'd0) begin
			if (col == 10'd0) begin
				win[0] = top; win[1] = top; win[2] = top;
				win[3] = mid; win[4] = mid; win[5] = mid;
				win[6] = bot; win[7] = bot; win[8] = bot;
			end else begin
				for (k = 0; k < 3; k++) begin
					win[k * 3] = win[k * 3 + 1];
					win[k * 3 + 1] = win[k * 3 + 2];
				end
				win[2] = top;
				win[5] = mid;
				win[8] = bot;
				filtered_q.push_back(switch_median(win, 1'b0));
			end
			if (row_end) begin
				for (k = 0; k < 3; k++) begin
					rim[k * 3] = win[k * 3 + 1];
					rim[k * 3 + 1] = win[k * 3 + 2];
					rim[k * 3 + 2] = win[k * 3 + 2];
				end
				filtered_q.push_back(switch_median(rim, draining));
			end
		end
		if (row_end) begin
			col = 10'd0;
			row = draining ? 11'd0 : row + 11'd1;
		end else begin
			col = col + 10'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			low_lvl = LOW_LEVEL_RST;
			high_lvl = HIGH_LEVEL_RST;
			for (i = 0; i < LINE_MAX; i++) begin
				upper_line[i] = 8'd0;
				lower_line[i] = 8'd0;
			end
			win = '0;
			col = 10'd0;
			row = 11'd0;
			filtered_q.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (filtered_q.size() == 0) begin
					$display("%0t: unexpected word: expected none, got value %0d replaced %0b last %0b",
						$time, value, replaced, last);
					errs++;
				end else begin
					head = filtered_q.pop_front();
					if (value !== head.value) begin
						$display("%0t: value mismatch: expected %0d, got %0d",
							$time, head.value, value);
						errs++;
					end
					if (replaced !== head.replaced) begin
						$display("%0t: replaced mismatch: expected %0b, got %0b",
							$time, head.replaced, replaced);
						errs++;
					end
					if (last !== head.last) begin
						$display("%0t: last mismatch: expected %0b, got %0b",
							$time, head.last, last);
						errs++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_WIDTH: width_reg = cfg_data;
					REG_FRAME_HEIGHT: height_reg = cfg_data;
					REG_LOW_LEVEL: low_lvl = cfg_data[7:0];
					default: high_lvl = cfg_data[7:0];
				endcase
			end
			if (in_valid && !in_stall)
				filter_word(opcode, pixel);
			fail_count <= errs;
			pending <= filtered_q.size();
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Top of the switching median filter testbench: clock, reset, register writes,
// pixel and drain words under varying idle and stall, and the verdict.
// Depends on isfm_pkg, impulse_switching_median_3x3_core and isfm_checker.
module tb;

	localparam int CYCLE_LIMIT = 100000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1650;

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [isfm_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [isfm_pkg::CFG_DATA_W-1:0]      cfg_data;
	logic                                 in_valid;
	logic                                 in_stall;
	logic                                 opcode;
	logic [7:0]                           pixel;
	logic                                 out_valid;
	logic                                 out_stall = 1'b1;
	logic [7:0]                           value;
	logic                                 replaced;
	logic                                 last;
	int                                   fail_count;
	int                                   pending;
	int                                   cycle_count = 0;
	int                                   send_pct = 0;
	int                                   recv_pct = 0;
	int                                   impulse_pct = 25;
	int                                   noise_pct = 0;
	logic [10:0]                          width_reg;
	logic [10:0]                          height_reg;
	isfm_pkg::pix_t                       lvl_low;
	isfm_pkg::pix_t                       lvl_high;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	impulse_switching_median_3x3_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.replaced  (replaced),
		.last      (last)
	);

	isfm_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.replaced   (replaced),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int clamp_size(input logic [10:0] v);
		if (v == 11'd0)
			return 1;
		if (v > 11'd1024)
			return 1024;
		return int'(v);
	endfunction

	function automatic isfm_pkg::pix_t pick_pixel();
		int r;
		r = $urandom_range(0, 99);
		if (r < impulse_pct) begin
			case ($urandom_range(0, 3))
				0: return lvl_low;
				1: return lvl_high;
				2: return 8'd0;
				default: return 8'd255;
			endcase
		end
		return isfm_pkg::pix_t'($urandom_range(0, 255));
	endfunction

	task automatic set_idle(input int phase);
		case (phase % 4)
			0: begin
				send_pct = 0;
				recv_pct = 0;
			end
			1: begin
				send_pct = 68;
				recv_pct = 0;
			end
			2: begin
				send_pct = 0;
				recv_pct = 68;
			end
			default: begin
				send_pct = 23;
				recv_pct = 23;
			end
		endcase
	endtask

	task automatic send_word(input logic op, input isfm_pkg::pix_t px);
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		pixel <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// hold until every predicted word has come out, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [isfm_pkg::CFG_IDX_W-1:0] idx,
			input logic [isfm_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			isfm_pkg::REG_FRAME_WIDTH: width_reg = data;
			isfm_pkg::REG_FRAME_HEIGHT: height_reg = data;
			isfm_pkg::REG_LOW_LEVEL: lvl_low = data[7:0];
			default: lvl_high = data[7:0];
		endcase
	endtask

	task automatic run_frame(input int hold_at);
		int w;
		int h;
		int n;
		w = clamp_size(width_reg);
		h = clamp_size(height_reg);
		for (n = 0; n < w * h; n++) begin
			if (n == hold_at)
				settle();
			if ($urandom_range(0, 99) < noise_pct)
				send_word(isfm_pkg::OP_DRAIN, isfm_pkg::pix_t'($urandom_range(0, 255)));
			send_word(isfm_pkg::OP_PIXEL, pick_pixel());
		end
		for (n = 0; n < w; n++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_word(isfm_pkg::OP_PIXEL, pick_pixel());
			send_word(isfm_pkg::OP_DRAIN, isfm_pkg::pix_t'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int frame_no;
		int rand_items;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= isfm_pkg::REG_FRAME_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		opcode <= isfm_pkg::OP_PIXEL;
		pixel <= 8'd0;
		width_reg = isfm_pkg::FRAME_WIDTH_RST;
		height_reg = isfm_pkg::FRAME_HEIGHT_RST;
		lvl_low = isfm_pkg::LOW_LEVEL_RST;
		lvl_high = isfm_pkg::HIGH_LEVEL_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(isfm_pkg::REG_FRAME_WIDTH, 11'd1);
		write_reg(isfm_pkg::REG_FRAME_HEIGHT, 11'd1);
		write_reg(isfm_pkg::REG_LOW_LEVEL, 11'd0);
		write_reg(isfm_pkg::REG_HIGH_LEVEL, 11'd255);
		send_word(isfm_pkg::OP_DRAIN, 8'd0);
		send_word(isfm_pkg::OP_PIXEL, 8'd255);
		send_word(isfm_pkg::OP_PIXEL, 8'd7);
		send_word(isfm_pkg::OP_DRAIN, 8'd0);
		settle();

		write_reg(isfm_pkg::REG_FRAME_WIDTH, 11'd0);
		write_reg(isfm_pkg::REG_FRAME_HEIGHT, 11'd0);
		send_word(isfm_pkg::OP_PIXEL, 8'd0);
		send_word(isfm_pkg::OP_DRAIN, 8'd255);
		settle();

		write_reg(isfm_pkg::REG_FRAME_WIDTH, 11'd3);
		write_reg(isfm_pkg::REG_FRAME_HEIGHT, 11'd2);
		send_word(isfm_pkg::OP_PIXEL, 8'd0);
		send_word(isfm_pkg::OP_PIXEL, 8'd255);
		send_word(isfm_pkg::OP_PIXEL, 8'd17);
		send_word(isfm_pkg::OP_PIXEL, 8'd128);
		send_word(isfm_pkg::OP_PIXEL, 8'd3);
		send_word(isfm_pkg::OP_PIXEL, 8'd200);
		send_word(isfm_pkg::OP_DRAIN, 8'hFF);
		send_word(isfm_pkg::OP_DRAIN, 8'h00);
		send_word(isfm_pkg::OP_DRAIN, 8'hA5);
		settle();

		write_reg(isfm_pkg::REG_FRAME_WIDTH, 11'd2);
		write_reg(isfm_pkg::REG_FRAME_HEIGHT, 11'd3);
		write_reg(isfm_pkg::REG_LOW_LEVEL, 11'd10);
		write_reg(isfm_pkg::REG_HIGH_LEVEL, 11'h7FA);
		send_word(isfm_pkg::OP_PIXEL, 8'd10);
		send_word(isfm_pkg::OP_PIXEL, 8'd250);
		send_word(isfm_pkg::OP_PIXEL, 8'd99);
		send_word(isfm_pkg::OP_PIXEL, 8'd100);
		send_word(isfm_pkg::OP_PIXEL, 8'd10);
		send_word(isfm_pkg::OP_PIXEL, 8'd101);
		send_word(isfm_pkg::OP_DRAIN, 8'd0);
		send_word(isfm_pkg::OP_DRAIN, 8'd0);
		settle();

		frame_no = 0;
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			set_idle(frame_no / 2);
			if (frame_no == 0 || $urandom_range(0, 2) == 0) begin
				settle();
				if (frame_no == 0 || $urandom_range(0, 1) == 1)
					write_reg(isfm_pkg::REG_FRAME_WIDTH, 11'($urandom_range(0, 20)));
				if (frame_no == 0 || $urandom_range(0, 1) == 1)
					write_reg(isfm_pkg::REG_FRAME_HEIGHT, 11'($urandom_range(0, 10)));
				if ($urandom_range(0, 1) == 1)
					write_reg(isfm_pkg::REG_LOW_LEVEL,
						($urandom_range(0, 3) == 0) ? 11'd0 :
						(($urandom_range(0, 2) == 0) ? 11'h7FF :
						11'($urandom_range(0, 2047))));
				if ($urandom_range(0, 1) == 1)
					write_reg(isfm_pkg::REG_HIGH_LEVEL,
						($urandom_range(0, 3) == 0) ? 11'h7FF :
						(($urandom_range(0, 2) == 0) ? 11'd0 :
						11'($urandom_range(0, 2047))));
			end
			impulse_pct = $urandom_range(0, 40);
			noise_pct = $urandom_range(0, 8);
			run_frame((frame_no % 7 == 3) ?
				clamp_size(width_reg) * clamp_size(height_reg) / 2 : -1);
			rand_items += clamp_size(width_reg) * (clamp_size(height_reg) + 1);
			frame_no++;
		end

		settle();
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
